[design/sia_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot id allocator package
// Request kinds, result status codes, field widths and the free list request.
// ----------------------------------------------------------------------------
package sia_pkg;

  localparam int unsigned IdW   = 10;
  localparam int unsigned WordW = 64;
  localparam int unsigned KindW = 2;
  localparam int unsigned StatW = 2;

  typedef enum logic [KindW-1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_LOOKUP  = 2'd2
  } kind_e;

  typedef enum logic [StatW-1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic pop;
    logic push;
  } fl_req_t;

endpackage

[design/slot_id_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot id allocator
// Handle table with a FIFO free list: allocate, release and lookup requests.
// ----------------------------------------------------------------------------
// An accepted item waits in the input register, beside the registered table read,
// until the result register is free, and its result is then registered there.
// Throughput: one item per cycle while the output is not stalled, set by the table
// and free list access between the input register and the result register.
// Reset clears the high-water mark, the free list pointers and the valid
// flags at once; the table and free list memories are not cleared.
module slot_id_allocator #(
  parameter int unsigned SLOTS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [79:0] s_axis_tdata_i,   // slot_id [9:0], entry_word [73:10], zero pad
  input  logic [1:0]  s_axis_tuser_i,   // kind [1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [79:0] m_axis_tdata_o,   // result_id [9:0], read_word [73:10], zero pad
  output logic [1:0]  m_axis_tuser_o    // status [1:0]
);

  localparam int unsigned IW    = $clog2(SLOTS);
  localparam int unsigned HW    = $clog2(SLOTS + 1);
  localparam int unsigned IdW   = sia_pkg::IdW;
  localparam int unsigned WordW = sia_pkg::WordW;

  logic                in_fire;
  logic                fire1;
  logic [IdW-1:0]      in_id;
  logic [IW+IdW-1:0]   in_id_wide;

  logic                v1_q, v1_d;
  logic [1:0]          kind1_q;
  logic [IdW-1:0]      id1_q;
  logic [WordW-1:0]    word1_q;

  logic                vo_q, vo_d;
  logic [IdW-1:0]      res_id_q;
  logic [WordW-1:0]    rd_word_q;
  logic [1:0]          status_q;

  logic [HW-1:0]       hw_q, hw_d;

  logic [WordW-1:0]    ent_rd;
  logic [IW-1:0]       fl_head;
  logic [HW-1:0]       fl_count;
  sia_pkg::fl_req_t    fl_req;

  logic [IW+IdW-1:0]   id1_wide;
  logic [IW-1:0]       id1_idx;
  logic [HW+IdW-1:0]   id1_ext;
  logic [HW+IdW-1:0]   hw_ext;
  logic [IW+IdW-1:0]   head_wide;
  logic [HW+IdW-1:0]   hw_wide;
  logic                id_in_range;
  logic                hw_avail;

  logic [IdW-1:0]      res_id_d;
  logic [WordW-1:0]    rd_word_d;
  logic [1:0]          status_d;
  logic                we_d;
  logic [IW-1:0]       waddr_d;
  logic [WordW-1:0]    wdata_d;
  logic                pop_d;
  logic                push_d;
  logic                hw_inc_d;

  assign fire1           = v1_q && (!vo_q || m_axis_tready_i);
  assign s_axis_tready_o = !v1_q || fire1;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  assign in_id      = s_axis_tdata_i[IdW-1:0];
  assign in_id_wide = {{IW{1'b0}}, in_id};

  always_comb begin
    v1_d = v1_q;
    if (in_fire) begin
      v1_d = 1'b1;
    end else if (fire1) begin
      v1_d = 1'b0;
    end
  end

  always_comb begin
    vo_d = vo_q;
    if (fire1) begin
      vo_d = 1'b1;
    end else if (m_axis_tready_i) begin
      vo_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      vo_q <= 1'b0;
      hw_q <= '0;
    end else begin
      v1_q <= v1_d;
      vo_q <= vo_d;
      hw_q <= hw_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind1_q <= s_axis_tuser_i;
      id1_q   <= in_id;
      word1_q <= s_axis_tdata_i[IdW+WordW-1:IdW];
    end
    if (fire1) begin
      res_id_q  <= res_id_d;
      rd_word_q <= rd_word_d;
      status_q  <= status_d;
    end
  end

  assign id1_wide    = {{IW{1'b0}}, id1_q};
  assign id1_idx     = id1_wide[IW-1:0];
  assign id1_ext     = {{HW{1'b0}}, id1_q};
  assign hw_ext      = {{IdW{1'b0}}, hw_q};
  assign head_wide   = {{IdW{1'b0}}, fl_head};
  assign hw_wide     = {{IdW{1'b0}}, hw_q};
  assign id_in_range = id1_ext < hw_ext;
  assign hw_avail    = hw_q < HW'(SLOTS);

  always_comb begin
    res_id_d  = id1_q;
    rd_word_d = '0;
    status_d  = sia_pkg::ST_OK;
    we_d      = 1'b0;
    waddr_d   = id1_idx;
    wdata_d   = word1_q;
    pop_d     = 1'b0;
    push_d    = 1'b0;
    hw_inc_d  = 1'b0;
    unique case (kind1_q)
      sia_pkg::KIND_ALLOC: begin
        if (fl_count != '0) begin
          pop_d    = 1'b1;
          we_d     = 1'b1;
          waddr_d  = fl_head;
          res_id_d = head_wide[IdW-1:0];
        end else if (hw_avail) begin
          we_d     = 1'b1;
          waddr_d  = hw_q[IW-1:0];
          res_id_d = hw_wide[IdW-1:0];
          hw_inc_d = 1'b1;
        end else begin
          res_id_d = '0;
          status_d = sia_pkg::ST_FULL;
        end
      end
      sia_pkg::KIND_RELEASE: begin
        if (id_in_range && (ent_rd != '0)) begin
          we_d    = 1'b1;
          wdata_d = '0;
          push_d  = 1'b1;
        end else begin
          status_d = sia_pkg::ST_BAD;
        end
      end
      sia_pkg::KIND_LOOKUP: begin
        if (id_in_range) begin
          rd_word_d = ent_rd;
        end
        if (!id_in_range || (ent_rd == '0)) begin
          status_d = sia_pkg::ST_BAD;
        end
      end
      default: begin
        status_d = sia_pkg::ST_BAD;
      end
    endcase
  end

  assign hw_d        = (fire1 && hw_inc_d) ? hw_q + 1'b1 : hw_q;
  assign fl_req.pop  = fire1 && pop_d;
  assign fl_req.push = fire1 && push_d;

  sia_entry_mem #(
    .SLOTS(SLOTS),
    .IW   (IW)
  ) u_entry_mem (
    .clk_i    (clk_i),
    .rd_en_i  (in_fire),
    .rd_addr_i(in_id_wide[IW-1:0]),
    .rd_data_o(ent_rd),
    .wr_en_i  (fire1 && we_d),
    .wr_addr_i(waddr_d),
    .wr_data_i(wdata_d)
  );

  sia_free_list #(
    .SLOTS(SLOTS),
    .IW   (IW),
    .HW   (HW)
  ) u_free_list (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (fl_req),
    .push_id_i(id1_idx),
    .head_id_o(fl_head),
    .count_o  (fl_count)
  );

  assign m_axis_tvalid_o = vo_q;
  assign m_axis_tdata_o  = {6'b0, rd_word_q, res_id_q};
  assign m_axis_tuser_o  = status_q;

  a_hw_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hw_q <= HW'(SLOTS))
    else $error("High-water mark is above the table size.");

  a_count_below_hw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fl_count <= hw_q)
    else $error("Free list holds more ids than slots ever granted.");

  a_hw_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire1 && hw_inc_d) |=> (hw_q == $past(hw_q) + 1'b1))
    else $error("Fresh allocation did not raise the high-water mark by one.");

  a_full_only_when_exhausted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire1 && (status_d == sia_pkg::ST_FULL)) |-> ((fl_count == '0) && !hw_avail))
    else $error("Table reported full while a slot was still free.");

endmodule

[design/sia_entry_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot id allocator entry table
// One write port and one registered read port; a write to the address being
// read in the same cycle is forwarded into the read register.
// ----------------------------------------------------------------------------
module sia_entry_mem #(
  parameter int unsigned SLOTS = 1024,
  parameter int unsigned IW    = 10
) (
  input  logic                      clk_i,
  input  logic                      rd_en_i,
  input  logic [IW-1:0]             rd_addr_i,
  output logic [sia_pkg::WordW-1:0] rd_data_o,
  input  logic                      wr_en_i,
  input  logic [IW-1:0]             wr_addr_i,
  input  logic [sia_pkg::WordW-1:0] wr_data_i
);

  logic [sia_pkg::WordW-1:0] mem [SLOTS];
  logic [sia_pkg::WordW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[design/sia_free_list.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot id allocator free list
// FIFO of released slot ids. The id at the head is read ahead every cycle, so
// it is ready in a register whenever an allocation needs it.
// ----------------------------------------------------------------------------
module sia_free_list #(
  parameter int unsigned SLOTS = 1024,
  parameter int unsigned IW    = 10,
  parameter int unsigned HW    = 11
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sia_pkg::fl_req_t req_i,
  input  logic [IW-1:0]    push_id_i,
  output logic [IW-1:0]    head_id_o,
  output logic [HW-1:0]    count_o
);

  logic [IW-1:0] mem [SLOTS];
  logic [IW-1:0] head_q, head_d;
  logic [IW-1:0] tail_q, tail_d;
  logic [HW-1:0] count_q, count_d;
  logic [IW-1:0] head_id_q;
  logic          push_ok;
  logic          pop_ok;

  function automatic logic [IW-1:0] ptr_next(input logic [IW-1:0] p);
    return (p == IW'(SLOTS - 1)) ? '0 : p + 1'b1;
  endfunction

  assign push_ok = req_i.push && (count_q < HW'(SLOTS));
  assign pop_ok  = req_i.pop && (count_q != '0);

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (pop_ok) begin
      head_d  = ptr_next(head_q);
      count_d = count_q - 1'b1;
    end
    if (push_ok) begin
      tail_d  = ptr_next(tail_q);
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem[tail_q] <= push_id_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok && (tail_q == head_d)) begin
      head_id_q <= push_id_i;
    end else begin
      head_id_q <= mem[head_d];
    end
  end

  assign head_id_o = head_id_q;
  assign count_o   = count_q;

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot id allocator testbench
// Drives allocate, release, lookup and unused request kinds into the handle
// table, first from a short table of directed items and then in random phases
// that mix requests, fill the table to its limit and churn the free list.
// Each result is checked against its typed reply or a behavioural model of
// the table and free list, while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned SLOTS        = 1024;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned QUIET_LIMIT  = 3000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned MIXED_ITEMS  = 150;
  localparam int unsigned CHURN_ITEMS  = 200;
  localparam int unsigned FULL_HITS    = 12;
  localparam logic [1:0]  KIND_UNUSED  = 2'd3;
  localparam logic [63:0] ONES         = '1;

  typedef struct packed {
    logic [sia_pkg::IdW-1:0]   rid;
    logic [sia_pkg::WordW-1:0] word;
    sia_pkg::status_e          status;
  } reply_t;

  typedef struct packed {
    logic [sia_pkg::KindW-1:0] kind;
    logic [sia_pkg::IdW-1:0]   id;
    logic [sia_pkg::WordW-1:0] word;
    logic                      typed;
    reply_t                    want;
  } row_t;

  localparam int unsigned ROWS = 25;
  localparam row_t DIRECTED [ROWS] = '{
    '{sia_pkg::KIND_LOOKUP,  10'd0,    64'd0, 1'b1, '{10'd0,    64'd0, sia_pkg::ST_BAD}},
    '{sia_pkg::KIND_RELEASE, 10'd1023, 64'd0, 1'b1, '{10'd1023, 64'd0, sia_pkg::ST_BAD}},
    '{KIND_UNUSED,           10'd5,    ONES,  1'b1, '{10'd5,    64'd0, sia_pkg::ST_BAD}},
    '{sia_pkg::KIND_ALLOC,   10'd1023, ONES,  1'b1, '{10'd0,    64'd0, sia_pkg::ST_OK}},
    '{sia_pkg::KIND_ALLOC,   10'd0,    64'd0, 1'b1, '{10'd1,    64'd0, sia_pkg::ST_OK}},
    '{sia_pkg::KIND_ALLOC,   10'd0,    64'd1, 1'b1, '{10'd2,    64'd0, sia_pkg::ST_OK}},
    '{sia_pkg::KIND_ALLOC,   10'd0,    64'h8000_0000_0000_0000, 1'b1,
      '{10'd3, 64'd0, sia_pkg::ST_OK}},
    '{sia_pkg::KIND_LOOKUP,  10'd0,    64'd0, 1'b1, '{10'd0,    ONES,  sia_pkg::ST_OK}},
    '{sia_pkg::KIND_LOOKUP,  10'd1,    64'd0, 1'b1, '{10'd1,    64'd0, sia_pkg::ST_BAD}},
    '{sia_pkg::KIND_LOOKUP,  10'd3,    64'd0, 1'b1,
      '{10'd3, 64'h8000_0000_0000_0000, sia_pkg::ST_OK}},
    '{sia_pkg::KIND_LOOKUP,  10'd4,    64'd0, 1'b1, '{10'd4,    64'd0, sia_pkg::ST_BAD}},
    '{sia_pkg::KIND_RELEASE, 10'd1,    64'd0, 1'b1, '{10'd1,    64'd0, sia_pkg::ST_BAD}},
    '{sia_pkg::KIND_RELEASE, 10'd4,    64'd0, 1'b1, '{10'd4,    64'd0, sia_pkg::ST_BAD}},
    '{sia_pkg::KIND_RELEASE, 10'd2,    64'd0, 1'b1, '{10'd2,    64'd0, sia_pkg::ST_OK}},
    '{sia_pkg::KIND_RELEASE, 10'd0,    64'd0, 1'b1, '{10'd0,    64'd0, sia_pkg::ST_OK}},
    '{sia_pkg::KIND_RELEASE, 10'd0,    64'd0, 1'b1, '{10'd0,    64'd0, sia_pkg::ST_BAD}},
    '{sia_pkg::KIND_LOOKUP,  10'd2,    64'd0, 1'b1, '{10'd2,    64'd0, sia_pkg::ST_BAD}},
    '{sia_pkg::KIND_ALLOC,   10'd0,    64'h0123_4567_89AB_CDEF, 1'b1,
      '{10'd2, 64'd0, sia_pkg::ST_OK}},
    '{sia_pkg::KIND_ALLOC,   10'd0,    64'hFEDC_BA98_7654_3210, 1'b1,
      '{10'd0, 64'd0, sia_pkg::ST_OK}},
    '{sia_pkg::KIND_ALLOC,   10'd0,    64'h5555_5555_5555_5555, 1'b1,
      '{10'd4, 64'd0, sia_pkg::ST_OK}},
    '{sia_pkg::KIND_LOOKUP,  10'd2,    64'd0, 1'b1,
      '{10'd2, 64'h0123_4567_89AB_CDEF, sia_pkg::ST_OK}},
    '{KIND_UNUSED,           10'd1023, 64'd0, 1'b1, '{10'd1023, 64'd0, sia_pkg::ST_BAD}},
    '{sia_pkg::KIND_LOOKUP,  10'd1023, 64'd0, 1'b1, '{10'd1023, 64'd0, sia_pkg::ST_BAD}},
    '{sia_pkg::KIND_ALLOC,   10'd0,    64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0},
    '{sia_pkg::KIND_RELEASE, 10'd4,    64'd0, 1'b0, '0}
  };

  logic                            clk     = 1'b0;
  logic                            rst_n   = 1'b0;
  logic                            s_valid = 1'b0;
  logic [79:0]                     s_tdata = '0;
  logic [sia_pkg::KindW-1:0]       s_tuser = '0;
  logic                            m_ready = 1'b0;
  logic                            s_axis_tready_o;
  logic                            m_axis_tvalid_o;
  logic [79:0]                     m_axis_tdata_o;
  logic [sia_pkg::StatW-1:0]       m_axis_tuser_o;

  logic [sia_pkg::WordW-1:0]       slot_word [SLOTS];
  logic [10:0]                     high_water = '0;
  logic [sia_pkg::IdW-1:0]         free_ids [$];
  reply_t                          pending_replies [$];

  int unsigned        mismatches   = 0;
  int unsigned        burst_left   = 0;
  int unsigned        quiet_cycles = 0;
  logic               hold_request = 1'b0;

  always #5 clk = ~clk;

  slot_id_allocator #(
    .SLOTS(SLOTS)
  ) dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  function automatic reply_t serve_request(input logic [sia_pkg::KindW-1:0] kind,
                                           input logic [sia_pkg::IdW-1:0] id,
                                           input logic [sia_pkg::WordW-1:0] word);
    reply_t r;
    r.rid    = id;
    r.word   = '0;
    r.status = sia_pkg::ST_OK;
    case (kind)
      sia_pkg::KIND_ALLOC: begin
        if (free_ids.size() > 0) begin
          r.rid = free_ids.pop_front();
          slot_word[r.rid] = word;
        end else if (high_water < SLOTS) begin
          r.rid = high_water[sia_pkg::IdW-1:0];
          slot_word[r.rid] = word;
          high_water = high_water + 11'd1;
        end else begin
          r.rid    = '0;
          r.status = sia_pkg::ST_FULL;
        end
      end
      sia_pkg::KIND_RELEASE: begin
        if (id < high_water && slot_word[id] != '0) begin
          slot_word[id] = '0;
          free_ids = {free_ids, id};
        end else begin
          r.status = sia_pkg::ST_BAD;
        end
      end
      sia_pkg::KIND_LOOKUP: begin
        if (id < high_water) begin
          r.word = slot_word[id];
        end
        if (r.word == '0) begin
          r.status = sia_pkg::ST_BAD;
        end
      end
      default: begin
        r.status = sia_pkg::ST_BAD;
      end
    endcase
    return r;
  endfunction

  function automatic logic [sia_pkg::IdW-1:0] pick_id();
    if (high_water != '0 && $urandom_range(9) < 7) begin
      return sia_pkg::IdW'($urandom_range(high_water - 11'd1));
    end
    return sia_pkg::IdW'($urandom);
  endfunction

  function automatic logic [sia_pkg::WordW-1:0] pick_word();
    case ($urandom_range(19))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Offers one item, honouring the burst and gap pattern of the sender, and
  // files its expected result once the item is accepted.
  task automatic offer_request(input logic [sia_pkg::KindW-1:0] kind,
                               input logic [sia_pkg::IdW-1:0] id,
                               input logic [sia_pkg::WordW-1:0] word, input logic typed,
                               input reply_t want);
    int unsigned gap;
    reply_t      predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left = burst_left - 1;
    s_valid <= 1'b1;
    s_tdata <= {6'd0, word, id};
    s_tuser <= kind;
    do @(posedge clk); while (!s_axis_tready_o);
    predicted = serve_request(kind, id, word);
    pending_replies = {pending_replies, (typed ? want : predicted)};
  endtask

  task automatic offer_random(input int unsigned pct_alloc, input int unsigned pct_release,
                              input int unsigned pct_lookup);
    int unsigned               r;
    logic [sia_pkg::KindW-1:0] kind;
    r = $urandom_range(99);
    if (r < pct_alloc) begin
      kind = sia_pkg::KIND_ALLOC;
    end else if (r < pct_alloc + pct_release) begin
      kind = sia_pkg::KIND_RELEASE;
    end else if (r < pct_alloc + pct_release + pct_lookup) begin
      kind = sia_pkg::KIND_LOOKUP;
    end else begin
      kind = KIND_UNUSED;
    end
    offer_request(kind, pick_id(), pick_word(), 1'b0, '0);
  endtask

  task automatic flag_mismatch(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    mismatches = mismatches + 1;
    if (mismatches <= 10) begin
      $display("mismatch in %s: expected %h, got %h", field, want, got);
    end
  endtask

  // Receiver: random stalls at a rate picked anew from a short list, with one long hold.
  initial begin
    int unsigned stall_pct;
    int unsigned rate_cycles;
    logic        hold_done;
    stall_pct   = 0;
    rate_cycles = 0;
    hold_done   = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        m_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (rate_cycles == 0) begin
          rate_cycles = 50;
          case ($urandom_range(3))
            0: stall_pct = 0;
            1: stall_pct = 10;
            2: stall_pct = 40;
            default: stall_pct = 75;
          endcase
        end
        rate_cycles = rate_cycles - 1;
        m_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin : check_result
    reply_t want;
    if (rst_n && m_axis_tvalid_o && m_ready) begin
      if (pending_replies.size() == 0) begin
        flag_mismatch("result with nothing pending", 64'd0, m_axis_tdata_o[73:10]);
      end else begin
        want = pending_replies.pop_front();
        if (m_axis_tdata_o[9:0] !== want.rid) begin
          flag_mismatch("result_id", 64'(want.rid), 64'(m_axis_tdata_o[9:0]));
        end
        if (m_axis_tdata_o[73:10] !== want.word) begin
          flag_mismatch("read_word", want.word, m_axis_tdata_o[73:10]);
        end
        if (m_axis_tuser_o !== want.status) begin
          flag_mismatch("status", 64'(want.status), 64'(m_axis_tuser_o));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    int unsigned full_seen;
    full_seen = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < ROWS; i++) begin
      offer_request(DIRECTED[i].kind, DIRECTED[i].id, DIRECTED[i].word,
                    DIRECTED[i].typed, DIRECTED[i].want);
    end

    for (int i = 0; i < MIXED_ITEMS; i++) begin
      offer_random(40, 30, 25);
    end

    // Let the pipeline run dry before filling the table.
    s_valid <= 1'b0;
    wait (pending_replies.size() == 0);
    @(posedge clk);
    burst_left = 0;

    // Fill the table with allocations and some lookups while the receiver holds
    // off, then keep asking until the full case has been seen several times.
    hold_request = 1'b1;
    while (full_seen < FULL_HITS) begin
      if ($urandom_range(99) < 85) begin
        if (high_water == SLOTS && free_ids.size() == 0) begin
          full_seen = full_seen + 1;
        end
        offer_request(sia_pkg::KIND_ALLOC, sia_pkg::IdW'($urandom), pick_word(), 1'b0, '0);
      end else begin
        offer_request(sia_pkg::KIND_LOOKUP, pick_id(), '0, 1'b0, '0);
      end
    end

    for (int i = 0; i < CHURN_ITEMS; i++) begin
      offer_random(35, 45, 18);
    end

    s_valid <= 1'b0;
    wait (pending_replies.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[filelist.f]
design/sia_pkg.sv
design/sia_entry_mem.sv
design/sia_free_list.sv
design/slot_id_allocator.sv
test/tb.sv
